@@ rtl/pfba_pkg.sv @@
// Shared types, codes and constants for the page-frame bitmap allocator.
package pfba_pkg;

    localparam int PAGE_TOTAL_DEF = 512;
    localparam int MAP_WORDS_DEF  = 16;
    localparam int WORD_BITS      = 32;
    localparam int BIT_W          = $clog2(WORD_BITS);

    localparam int ACT_W  = 2;
    localparam int PAGE_W = 9;
    localparam int RES_W  = 10;
    localparam int CNT_W  = 10;
    localparam int ST_W   = 2;

    localparam logic [RES_W-1:0] RESERVED_RST = 10'd1;

    localparam logic [ACT_W-1:0] ACT_INIT  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_ALLOC = 2'd1;
    localparam logic [ACT_W-1:0] ACT_FREE  = 2'd2;

    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_NO_FREE  = 2'd1;
    localparam logic [ST_W-1:0] ST_BAD_FREE = 2'd2;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [PAGE_W-1:0] page_number;
    } pfba_in_t;

    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [PAGE_W-1:0] granted_page;
        logic [CNT_W-1:0]  free_count;
    } pfba_out_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_SCAN,
        S_EXEC,
        S_DONE
    } pfba_state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic step;
        logic commit;
        logic emit;
    } pfba_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic             hit;
        logic             last_word;
        logic             slot_free;
    } pfba_stat_t;

endpackage

@@ rtl/pfba_ctrl.sv @@
// Sequencing state machine for the page-frame bitmap allocator.
module pfba_ctrl
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    input  logic [pfba_pkg::ACT_W-1:0]      req_action,
    output logic                            req_ready,
    input  pfba_pkg::pfba_stat_t            stat,
    output pfba_pkg::pfba_cmd_t             cmd
);

    pfba_pkg::pfba_state_t state_reg;
    pfba_pkg::pfba_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pfba_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pfba_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    if (req_action inside {pfba_pkg::ACT_ALLOC, pfba_pkg::ACT_FREE})
                    begin
                        state_next = pfba_pkg::S_FETCH;
                    end
                    else
                    begin
                        state_next = pfba_pkg::S_EXEC;
                    end
                end
            end
            pfba_pkg::S_FETCH:
            begin
                if (stat.action == pfba_pkg::ACT_ALLOC)
                begin
                    state_next = pfba_pkg::S_SCAN;
                end
                else
                begin
                    state_next = pfba_pkg::S_EXEC;
                end
            end
            pfba_pkg::S_SCAN:
            begin
                if (stat.hit || stat.last_word)
                begin
                    state_next = pfba_pkg::S_DONE;
                end
            end
            pfba_pkg::S_EXEC:
            begin
                state_next = pfba_pkg::S_DONE;
            end
            pfba_pkg::S_DONE:
            begin
                if (stat.slot_free)
                begin
                    state_next = pfba_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = pfba_pkg::S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd       = '0;
        req_ready = 1'b0;
        case (state_reg)
            pfba_pkg::S_IDLE:
            begin
                req_ready = 1'b1;
                cmd.load  = req_valid;
            end
            pfba_pkg::S_FETCH:
            begin
                cmd.step = (stat.action == pfba_pkg::ACT_ALLOC);
            end
            pfba_pkg::S_SCAN:
            begin
                cmd.step   = 1'b1;
                cmd.commit = stat.hit || stat.last_word;
            end
            pfba_pkg::S_EXEC:
            begin
                cmd.commit = 1'b1;
            end
            pfba_pkg::S_DONE:
            begin
                cmd.emit = stat.slot_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // a scan never outlives the map: the last word always ends it
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pfba_pkg::S_SCAN && stat.last_word) |=> (state_reg == pfba_pkg::S_DONE))
        else $error("scan ran past the last map word");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> (state_reg == pfba_pkg::S_DONE))
        else $error("commit not followed by result hand-off");

endmodule

@@ rtl/pfba_datapath.sv @@
// Bitmap store, word scanner, free counter and result registers.
module pfba_datapath
#(
    parameter int PAGE_TOTAL = pfba_pkg::PAGE_TOTAL_DEF,
    parameter int MAP_WORDS  = pfba_pkg::MAP_WORDS_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  pfba_pkg::pfba_cmd_t            cmd,
    output pfba_pkg::pfba_stat_t           stat,
    input  pfba_pkg::pfba_in_t             req,
    input  logic                           cfg_valid,
    input  logic [pfba_pkg::RES_W-1:0]     cfg_data,
    input  logic                           rsp_ready,
    output logic                           rsp_valid,
    output pfba_pkg::pfba_out_t            rsp
);

    localparam int WB    = pfba_pkg::WORD_BITS;
    localparam int BW    = pfba_pkg::BIT_W;
    localparam int CAP   = MAP_WORDS * WB;
    localparam int LIMIT = (PAGE_TOTAL < CAP) ? PAGE_TOTAL : CAP;
    localparam int AW    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int XW    = AW + BW + 1;
    localparam int FW    = $clog2(LIMIT + 1);
    localparam int CW    = (XW > pfba_pkg::RES_W) ? XW : pfba_pkg::RES_W;

    // mask of bits in word w whose page number lies below lvl
    function automatic logic [WB-1:0] fill_below(input logic [XW-1:0] lvl,
                                                 input logic [AW-1:0] w);
        logic [XW-1:0] base;
        logic [XW-1:0] diff;
        logic [WB-1:0] m;
        base = XW'(w) << BW;
        diff = lvl - base;
        if (lvl >= base + XW'(WB))
        begin
            m = '1;
        end
        else if (lvl > base)
        begin
            m = (WB'(1) << diff[BW-1:0]) - WB'(1);
        end
        else
        begin
            m = '0;
        end
        return m;
    endfunction

    logic [WB-1:0]                  mem [MAP_WORDS];
    logic [MAP_WORDS-1:0]           word_vld_reg;
    logic [FW-1:0]                  init_res_reg;
    logic [FW-1:0]                  free_cnt_reg;
    logic [pfba_pkg::RES_W-1:0]     cfg_res_reg;
    logic [pfba_pkg::ACT_W-1:0]     act_reg;
    logic [pfba_pkg::PAGE_W-1:0]    page_reg;
    logic [AW-1:0]                  rd_addr_reg;
    logic [AW-1:0]                  rd_word_reg;
    logic [WB-1:0]                  rd_data_reg;
    logic                           rd_wvld_reg;
    pfba_pkg::pfba_out_t            res_reg;
    pfba_pkg::pfba_out_t            res_next;
    pfba_pkg::pfba_out_t            out_reg;
    logic                           out_valid_reg;

    logic [WB-1:0]                  eff_word;
    logic [WB-1:0]                  avail;
    logic                           hit;
    logic [BW-1:0]                  hit_bit;
    logic [AW+BW-1:0]               hit_page;
    logic                           free_ok;
    logic [FW-1:0]                  res_clamp;
    logic [FW-1:0]                  init_cnt;
    logic [FW-1:0]                  cnt_dec;
    logic [FW-1:0]                  cnt_inc;
    logic                           mem_we;
    logic [WB-1:0]                  wr_word;

    // words not written since init read as the init pattern
    assign eff_word = rd_wvld_reg ? rd_data_reg : fill_below(XW'(init_res_reg), rd_word_reg);
    // pages beyond the managed range count as taken
    assign avail    = ~(eff_word | ~fill_below(XW'(LIMIT), rd_word_reg));
    assign hit      = |avail;

    always_comb
    begin
        hit_bit = '0;
        for (int i = WB - 1; i >= 0; i--)
        begin
            if (avail[i])
            begin
                hit_bit = BW'(i);
            end
        end
    end

    assign hit_page = {rd_word_reg, hit_bit};

    assign free_ok = (CW'(page_reg) < CW'(LIMIT)) && (CW'(page_reg) >= CW'(cfg_res_reg))
                     && eff_word[page_reg[BW-1:0]];

    assign res_clamp = (CW'(cfg_res_reg) > CW'(LIMIT)) ? FW'(LIMIT) : FW'(cfg_res_reg);
    assign init_cnt  = FW'(LIMIT) - res_clamp;
    assign cnt_dec   = (free_cnt_reg != '0) ? free_cnt_reg - FW'(1) : free_cnt_reg;
    assign cnt_inc   = free_cnt_reg + FW'(1);

    assign mem_we  = cmd.commit && (((act_reg == pfba_pkg::ACT_ALLOC) && hit)
                                    || ((act_reg == pfba_pkg::ACT_FREE) && free_ok));
    assign wr_word = (act_reg == pfba_pkg::ACT_ALLOC)
                     ? (eff_word | (WB'(1) << hit_bit))
                     : (eff_word & ~(WB'(1) << page_reg[BW-1:0]));

    always_comb
    begin
        res_next.status       = pfba_pkg::ST_OK;
        res_next.granted_page = '0;
        res_next.free_count   = pfba_pkg::CNT_W'(free_cnt_reg);
        case (act_reg)
            pfba_pkg::ACT_INIT:
            begin
                res_next.free_count = pfba_pkg::CNT_W'(init_cnt);
            end
            pfba_pkg::ACT_ALLOC:
            begin
                if (hit)
                begin
                    res_next.granted_page = pfba_pkg::PAGE_W'(hit_page);
                    res_next.free_count   = pfba_pkg::CNT_W'(cnt_dec);
                end
                else
                begin
                    res_next.status = pfba_pkg::ST_NO_FREE;
                end
            end
            pfba_pkg::ACT_FREE:
            begin
                if (free_ok)
                begin
                    res_next.free_count = pfba_pkg::CNT_W'(cnt_inc);
                end
                else
                begin
                    res_next.status = pfba_pkg::ST_BAD_FREE;
                end
            end
            default:
            begin
                res_next.status = pfba_pkg::ST_OK;
            end
        endcase
    end

    // bitmap store: one read and one write port
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr_reg];
        if (mem_we)
        begin
            mem[rd_word_reg] <= wr_word;
        end
    end

    // item and read-side payload
    always_ff @(posedge clk)
    begin
        rd_word_reg <= rd_addr_reg;
        rd_wvld_reg <= word_vld_reg[rd_addr_reg];
        if (cmd.load)
        begin
            act_reg  <= req.action;
            page_reg <= req.page_number;
        end
        if (cmd.commit)
        begin
            res_reg <= res_next;
        end
        if (cmd.emit)
        begin
            out_reg <= res_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_addr_reg   <= '0;
            word_vld_reg  <= '0;
            init_res_reg  <= '0;
            free_cnt_reg  <= FW'(LIMIT);
            cfg_res_reg   <= pfba_pkg::RESERVED_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                cfg_res_reg <= cfg_data;
            end

            if (cmd.load)
            begin
                rd_addr_reg <= (req.action == pfba_pkg::ACT_FREE)
                               ? AW'(req.page_number >> BW) : '0;
            end
            else if (cmd.step && (rd_addr_reg != AW'(MAP_WORDS - 1)))
            begin
                rd_addr_reg <= rd_addr_reg + AW'(1);
            end

            if (cmd.commit)
            begin
                case (act_reg)
                    pfba_pkg::ACT_INIT:
                    begin
                        word_vld_reg <= '0;
                        init_res_reg <= res_clamp;
                        free_cnt_reg <= init_cnt;
                    end
                    pfba_pkg::ACT_ALLOC:
                    begin
                        if (hit)
                        begin
                            word_vld_reg[rd_word_reg] <= 1'b1;
                            free_cnt_reg              <= cnt_dec;
                        end
                    end
                    pfba_pkg::ACT_FREE:
                    begin
                        if (free_ok)
                        begin
                            word_vld_reg[rd_word_reg] <= 1'b1;
                            free_cnt_reg              <= cnt_inc;
                        end
                    end
                    default:
                    begin
                        free_cnt_reg <= free_cnt_reg;
                    end
                endcase
            end

            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.action    = act_reg;
    assign stat.hit       = hit;
    assign stat.last_word = (rd_word_reg == AW'(MAP_WORDS - 1));
    assign stat.slot_free = !out_valid_reg || rsp_ready;

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        CW'(free_cnt_reg) <= CW'(LIMIT))
        else $error("free count above managed page count");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && act_reg == pfba_pkg::ACT_ALLOC && hit)
            |-> (XW'(hit_page) < XW'(LIMIT)))
        else $error("granted page outside managed range");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.status != pfba_pkg::ST_OK) |-> (out_reg.granted_page == '0))
        else $error("page granted on a failed word");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && act_reg == pfba_pkg::ACT_FREE && free_ok)
            |-> (CW'(page_reg) >= CW'(cfg_res_reg)))
        else $error("reserved page released");

endmodule

@@ rtl/page_frame_bitmap_allocator_unit.sv @@
// Top level of the first-fit page-frame bitmap allocator.
// Steps: init and unused codes run idle, exec, done; free runs idle, fetch, exec,
//   done; allocate runs idle, fetch, scan to the first free page's word, done.
// Throughput: one word at a time; the allocate scan reads one bitmap word per
//   cycle through the single read port of the map store.
// Reset: map all free, free count = managed pages, reserved_pages = 1; no clearing pass.
module page_frame_bitmap_allocator_unit
#(
    parameter int PAGE_TOTAL = pfba_pkg::PAGE_TOTAL_DEF,
    parameter int MAP_WORDS  = pfba_pkg::MAP_WORDS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    // request words: action and page to free
    input  logic                        req_valid,
    output logic                        req_ready,
    input  pfba_pkg::pfba_in_t          req,
    // response words: status, granted page, free count
    output logic                        rsp_valid,
    input  logic                        rsp_ready,
    output pfba_pkg::pfba_out_t         rsp,
    // reserved_pages register write
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [pfba_pkg::RES_W-1:0]  cfg_data
);

    pfba_pkg::pfba_cmd_t  cmd;
    pfba_pkg::pfba_stat_t stat;

    // The register is a plain flop; writes land at once.
    assign cfg_ready = 1'b1;

    // Controller: accepts a request word only when idle. The response sits in
    // an output register, so a new request can start while the last response
    // waits to be taken; the next one is held until that slot drains.
    pfba_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_action (req.action),
        .req_ready  (req_ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    // Datapath: bitmap store with per-word valid flags (an unwritten word
    // reads as the pattern laid down by the last init), first-zero finder,
    // free counter and response registers.
    pfba_datapath
    #(
        .PAGE_TOTAL (PAGE_TOTAL),
        .MAP_WORDS  (MAP_WORDS)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .req       (req),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .rsp_ready (rsp_ready),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

endmodule

@@ test/page_frame_bitmap_allocator_unit_tb.sv @@
// Self-checking testbench for the first-fit page-frame bitmap allocator.

// Tracks the page map the block should hold and the answers it owes.
class frame_ledger;

    localparam int unsigned MAP_DEPTH  = pfba_pkg::MAP_WORDS_DEF;
    localparam int unsigned PAGE_LIMIT =
        (pfba_pkg::PAGE_TOTAL_DEF < pfba_pkg::MAP_WORDS_DEF * pfba_pkg::WORD_BITS) ?
        pfba_pkg::PAGE_TOTAL_DEF : pfba_pkg::MAP_WORDS_DEF * pfba_pkg::WORD_BITS;
    localparam int unsigned LINE_CAP   = 40;

    logic [31:0]         used_map [MAP_DEPTH];
    int unsigned         free_pages;
    int unsigned         reserved_pages;
    int unsigned         errors;
    int unsigned         answers_seen;
    pfba_pkg::pfba_out_t owed_answers [$];

    function new();
        foreach (used_map[w])
            used_map[w] = '0;
        free_pages     = PAGE_LIMIT;
        reserved_pages = 32'(pfba_pkg::RESERVED_RST);
        errors         = 0;
        answers_seen   = 0;
    endfunction

    function void set_reserved(logic [pfba_pkg::RES_W-1:0] value);
        reserved_pages = 32'(value);
    endfunction

    function int pending();
        return owed_answers.size();
    endfunction

    // Apply one accepted request word to the shadow map and queue its answer.
    function void log_request(pfba_pkg::pfba_in_t word);
        pfba_pkg::pfba_out_t ans;
        int unsigned         res;
        int unsigned         base;
        int unsigned         p;
        int unsigned         w;
        logic [31:0]         bit_mask;
        bit                  found;
        ans = '0;
        case (word.action)
            pfba_pkg::ACT_INIT:
            begin
                res = (reserved_pages > PAGE_LIMIT) ? PAGE_LIMIT : reserved_pages;
                for (w = 0; w < MAP_DEPTH; w++)
                begin
                    base = w * pfba_pkg::WORD_BITS;
                    if (res >= base + pfba_pkg::WORD_BITS)
                        used_map[w] = 32'hffff_ffff;
                    else if (res > base)
                        used_map[w] = (32'h0000_0001 << (res - base)) - 32'h0000_0001;
                    else
                        used_map[w] = '0;
                end
                free_pages = PAGE_LIMIT - res;
            end
            pfba_pkg::ACT_ALLOC:
            begin
                found = 1'b0;
                for (p = 0; p < PAGE_LIMIT && !found; p++)
                begin
                    w        = p / pfba_pkg::WORD_BITS;
                    bit_mask = 32'h0000_0001 << (p % pfba_pkg::WORD_BITS);
                    if ((used_map[w] & bit_mask) == '0)
                    begin
                        used_map[w] |= bit_mask;
                        if (free_pages > 0)
                            free_pages--;
                        ans.granted_page = p[pfba_pkg::PAGE_W-1:0];
                        found = 1'b1;
                    end
                end
                if (!found)
                    ans.status = pfba_pkg::ST_NO_FREE;
            end
            pfba_pkg::ACT_FREE:
            begin
                p = 32'(word.page_number);
                if (p >= PAGE_LIMIT || p < reserved_pages)
                    ans.status = pfba_pkg::ST_BAD_FREE;
                else
                begin
                    w        = p / pfba_pkg::WORD_BITS;
                    bit_mask = 32'h0000_0001 << (p % pfba_pkg::WORD_BITS);
                    if ((used_map[w] & bit_mask) == '0)
                        ans.status = pfba_pkg::ST_BAD_FREE;
                    else
                    begin
                        used_map[w] &= ~bit_mask;
                        free_pages++;
                    end
                end
            end
            default:
            begin
                // spare action code: no change, plain ok answer
            end
        endcase
        ans.free_count = free_pages[pfba_pkg::CNT_W-1:0];
        owed_answers.push_back(ans);
    endfunction

    task flag_mismatch(string what, logic [15:0] got, logic [15:0] want);
        if (errors < LINE_CAP)
            $display("MISMATCH answer %0d %s: got %0d want %0d", answers_seen, what, got, want);
        errors++;
    endtask

    task match_answer(pfba_pkg::pfba_out_t got);
        pfba_pkg::pfba_out_t want;
        if (owed_answers.size() == 0)
            flag_mismatch("unexpected word", 16'(got.free_count), 16'd0);
        else
        begin
            want = owed_answers.pop_front();
            if (got.status !== want.status)
                flag_mismatch("status", 16'(got.status), 16'(want.status));
            if (got.granted_page !== want.granted_page)
                flag_mismatch("granted_page", 16'(got.granted_page), 16'(want.granted_page));
            if (got.free_count !== want.free_count)
                flag_mismatch("free_count", 16'(got.free_count), 16'(want.free_count));
        end
        answers_seen++;
    endtask

endclass

module page_frame_bitmap_allocator_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // The package names three actions; the fourth code must still be exercised.
    localparam logic [pfba_pkg::ACT_W-1:0] ACT_SPARE = 2'd3;

    localparam int RANDOM_WORDS   = 1050;
    // Leave a little slack after the worst allocate.
    localparam int SETTLE_CYCLES  = 24;
    // Worst quiet stretch in a correct run is set by a full-map scan, the longest
    // receive stall and the longest send gap.
    localparam int WATCHDOG_LIMIT = 2000;

    logic                         clk;
    logic                         rst_n;
    logic                         req_valid;
    logic                         req_ready;
    pfba_pkg::pfba_in_t           req;
    logic                         rsp_valid;
    logic                         rsp_ready;
    pfba_pkg::pfba_out_t          rsp;
    logic                         cfg_valid;
    logic                         cfg_ready;
    logic [pfba_pkg::RES_W-1:0]   cfg_data;

    frame_ledger ledger;

    int burst_left;
    int random_sent;
    int idle_cycles;
    int stall_mode;
    int stall_span;
    int stall_tick;

    page_frame_bitmap_allocator_unit uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Offer one request word; the sender works in bursts with random gaps
    // between them, and some gaps are zero so long unbroken runs occur too.
    task automatic send_word(input logic [pfba_pkg::ACT_W-1:0] act,
                             input logic [pfba_pkg::PAGE_W-1:0] page);
        pfba_pkg::pfba_in_t word;
        int                 gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            repeat (gap)
            begin
                @(negedge clk);
                req_valid <= 1'b0;
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        word.action      = act;
        word.page_number = page;
        @(negedge clk);
        req_valid <= 1'b1;
        req       <= word;
        do
            @(posedge clk);
        while (!req_ready);
        ledger.log_request(word);
    endtask

    // Drop valid, wait for every owed answer, then let the block go quiet.
    task automatic settle_block();
        @(negedge clk);
        req_valid <= 1'b0;
        while (ledger.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register writes only ever happen with the block drained.
    task automatic write_reserved(input logic [pfba_pkg::RES_W-1:0] value);
        settle_block();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        ledger.set_reserved(value);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly allocs and frees of pages likely to be in use (the low end of the
    // map, just above the reserved block), with stray frees, spare codes and
    // the odd re-init mixed in.
    task automatic random_word(input int alloc_pct);
        int                          r;
        int                          hi;
        int                          lo;
        logic [pfba_pkg::ACT_W-1:0]  act;
        logic [pfba_pkg::PAGE_W-1:0] page;
        r    = $urandom_range(0, 99);
        page = pfba_pkg::PAGE_W'($urandom_range(0, 511));
        if (r < alloc_pct)
            act = pfba_pkg::ACT_ALLOC;
        else if (r < 84)
        begin
            act = pfba_pkg::ACT_FREE;
            hi  = 512 - int'(ledger.free_pages) + 3;
            if (hi > 511)
                hi = 511;
            lo  = (int'(ledger.reserved_pages) > hi) ? hi : int'(ledger.reserved_pages);
            page = pfba_pkg::PAGE_W'($urandom_range(hi, lo));
        end
        else if (r < 93)
            act = pfba_pkg::ACT_FREE;
        else if (r < 97)
            act = ACT_SPARE;
        else
            act = pfba_pkg::ACT_INIT;
        send_word(act, page);
    endtask

    // Short directed run over the corner cases before the random phases.
    task automatic run_directed();
        // straight out of reset the map is empty, so page 0 goes first
        send_word(pfba_pkg::ACT_ALLOC, 9'd0);
        send_word(pfba_pkg::ACT_FREE, 9'd0);      // below the reserved count
        send_word(ACT_SPARE, 9'd511);             // spare code: no effect
        send_word(pfba_pkg::ACT_INIT, 9'd0);
        send_word(pfba_pkg::ACT_ALLOC, 9'd0);
        send_word(pfba_pkg::ACT_FREE, 9'd1);
        send_word(pfba_pkg::ACT_FREE, 9'd1);      // already free
        send_word(pfba_pkg::ACT_FREE, 9'd511);    // never used
        // whole map reserved
        write_reserved(10'd512);
        send_word(pfba_pkg::ACT_INIT, 9'd0);
        send_word(pfba_pkg::ACT_ALLOC, 9'd0);     // nothing free
        send_word(pfba_pkg::ACT_FREE, 9'd511);
        // reserved count beyond the map is clamped
        write_reserved(10'd1023);
        send_word(pfba_pkg::ACT_INIT, 9'd511);
        send_word(pfba_pkg::ACT_ALLOC, 9'd0);
        // no reserved pages: page 0 may be released and taken again
        write_reserved(10'd0);
        send_word(pfba_pkg::ACT_FREE, 9'd0);
        send_word(pfba_pkg::ACT_ALLOC, 9'd0);
        send_word(pfba_pkg::ACT_INIT, 9'd0);
        send_word(pfba_pkg::ACT_ALLOC, 9'd0);
        send_word(pfba_pkg::ACT_FREE, 9'd0);
        // single free page at the very top: full-length scan
        write_reserved(10'd511);
        send_word(pfba_pkg::ACT_INIT, 9'd0);
        send_word(pfba_pkg::ACT_ALLOC, 9'd0);
        send_word(pfba_pkg::ACT_ALLOC, 9'd0);
        send_word(pfba_pkg::ACT_FREE, 9'd511);
        send_word(pfba_pkg::ACT_FREE, 9'd256);
        // reserved block ending one past a word boundary
        write_reserved(10'd33);
        send_word(pfba_pkg::ACT_INIT, 9'd0);
        send_word(pfba_pkg::ACT_ALLOC, 9'd0);
    endtask

    // Receiver: ready follows a pattern that changes every so often - always
    // ready, coin toss, two in three, or long stalls with a rare ready.
    initial
    begin
        rsp_ready  = 1'b0;
        stall_tick = 0;
        forever
        begin
            stall_mode = $urandom_range(0, 3);
            stall_span = $urandom_range(8, 60);
            repeat (stall_span)
            begin
                @(negedge clk);
                stall_tick++;
                case (stall_mode)
                    0:       rsp_ready <= 1'b1;
                    1:       rsp_ready <= 1'($urandom_range(0, 1));
                    2:       rsp_ready <= (stall_tick % 3 != 0);
                    default: rsp_ready <= (stall_tick % 16 == 0);
                endcase
            end
        end
    end

    // Answers are checked as they are taken, in order.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
            ledger.match_answer(rsp);
    end

    // Watchdog: ends the run if nothing is taken on any channel for too long.
    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
                (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        int n_words;
        int alloc_pct;
        int reserved_pick;

        ledger      = new();
        burst_left  = 0;
        random_sent = 0;
        rst_n       = 1'b0;
        req_valid   = 1'b0;
        req         = '0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        run_directed();

        // Random phases: new reserved count, re-init, then a run of words.
        // High reserved counts keep the map near full so no-free answers turn up.
        while (random_sent < RANDOM_WORDS)
        begin
            case ($urandom_range(0, 5))
                0:       reserved_pick = 0;
                1:       reserved_pick = $urandom_range(1, 40);
                2:       reserved_pick = $urandom_range(41, 470);
                3:       reserved_pick = $urandom_range(471, 512);
                4:       reserved_pick = $urandom_range(513, 1023);
                default: reserved_pick = 1;
            endcase
            case ($urandom_range(0, 2))
                0:       alloc_pct = 30;
                1:       alloc_pct = 50;
                default: alloc_pct = 75;
            endcase
            write_reserved(reserved_pick[pfba_pkg::RES_W-1:0]);
            send_word(pfba_pkg::ACT_INIT, pfba_pkg::PAGE_W'($urandom_range(0, 511)));
            n_words = $urandom_range(50, 130);
            repeat (n_words) random_word(alloc_pct);
            random_sent += n_words + 1;
        end

        settle_block();
        if (ledger.pending() != 0)
            ledger.flag_mismatch("answers never returned", 16'(ledger.pending()), 16'd0);

        if (ledger.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

@@ files.f @@
rtl/pfba_pkg.sv
rtl/pfba_ctrl.sv
rtl/pfba_datapath.sv
rtl/page_frame_bitmap_allocator_unit.sv
test/page_frame_bitmap_allocator_unit_tb.sv
